FILE: sv/bbce_pkg.sv
// Shared types and constants for the bass band compressor enhancer.
package bbce_pkg;

    // Configuration port
    localparam int CFG_W = 32;

    typedef enum logic [2:0] {
        CFG_AMOUNT    = 3'd0,
        CFG_THRESHOLD = 3'd1,
        CFG_SLOPE     = 3'd2,
        CFG_ATTACK    = 3'd3,
        CFG_RELEASE   = 3'd4,
        CFG_B0        = 3'd5,
        CFG_A1        = 3'd6,
        CFG_A2        = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [16:0]        RST_AMOUNT    = 17'd0;
    localparam logic signed [14:0] RST_THRESHOLD = -15'sd3072;
    localparam logic signed [16:0] RST_SLOPE     = -17'sd32768;
    localparam logic [23:0]        RST_ATTACK    = 24'd0;
    localparam logic [23:0]        RST_RELEASE   = 24'd0;
    localparam logic signed [31:0] RST_B0        = 32'sd268435456;
    localparam logic signed [31:0] RST_A1        = 32'sd0;
    localparam logic signed [31:0] RST_A2        = 32'sd0;

    // dB per octave and octave per dB, both Q16
    localparam logic [18:0] DB_PER_OCT_Q16 = 19'd394566;
    localparam logic [13:0] OCT_PER_DB_Q16 = 14'd10885;

    // Band gain floor in dB, signed Q7.8 (15 bits)
    localparam logic signed [14:0] GAIN_FLOOR = -15'sd12800;

    // Log and exp table entries
    localparam int TAB_W = 18;
    typedef logic [TAB_W-1:0] t_tab;

endpackage

FILE: sv/bbce_in_if.sv
// Input sample channel: valid, ready and one dry sample word.
interface bbce_in_if #(parameter int SW = 24) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

FILE: sv/bbce_out_if.sv
// Result channel: valid, ready, enhanced sample and applied band gain.
interface bbce_out_if #(parameter int SW = 24) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] out_sample;
    logic signed [14:0]   gain_reduction;

    modport source (output valid, output out_sample, output gain_reduction, input ready);
    modport sink   (input valid, input out_sample, input gain_reduction, output ready);
endinterface

FILE: sv/bass_band_compress_enhancer.sv
// Bass band compressor enhancer top level: sequencer around one shared multiplier.
//
//  channel   | dir | handshake        | word
//  ----------+-----+------------------+----------------------------------------
//  i_in      | in  | valid / ready    | in_sample
//  o_out     | out | valid / ready    | out_sample, gain_reduction
//  cfg write | in  | i_cfg_we         | i_cfg_idx, i_cfg_data
//
//  A bypassed word (amount zero) goes straight to the done state. Otherwise a
//  word's time depends on the normalize steps of the envelope, since every
//  product goes through the one multiplier in turn.
//  Reset is synchronous, active low; it clears filter history and envelope.
//  A finished word waits in the output register while the next is accepted.
module bass_band_compress_enhancer import bbce_pkg::*; #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int LOG_TABLE_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bbce_in_if.sink          i_in,
    bbce_out_if.source       o_out
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int EW   = SW + 2;
    localparam int OPW  = (SW + 3 > 33) ? SW + 3 : 33;
    localparam int PW   = 2 * OPW;
    localparam int ACCW = PW + 3;
    localparam int IW   = $clog2(LOG_TABLE_DEPTH + 1);
    localparam int CW   = $clog2(EW);
    localparam int LGW  = CW + 18;

    localparam logic signed [PW-1:0]   RND7   = PW'(128);
    localparam logic signed [PW-1:0]   RND15  = PW'(32768);
    localparam logic signed [PW-1:0]   RND23  = PW'(8388608);
    localparam logic signed [ACCW-1:0] RND27  = ACCW'(134217728);
    localparam logic signed [ACCW-1:0] SMAX_A = (ACCW'(1) <<< (SW - 1)) - ACCW'(1);
    localparam logic signed [ACCW-1:0] SMIN_A = -SMAX_A - ACCW'(1);
    localparam logic [EW-1:0]          ENV_MAX = EW'(1) << (SW + 1);

    typedef enum logic [27:0] {
        S_IDLE = 28'd1 << 0,
        S_F0   = 28'd1 << 1,
        S_F1   = 28'd1 << 2,
        S_F2   = 28'd1 << 3,
        S_F3   = 28'd1 << 4,
        S_F4   = 28'd1 << 5,
        S_F5   = 28'd1 << 6,
        S_F6   = 28'd1 << 7,
        S_ENV0 = 28'd1 << 8,
        S_ENV1 = 28'd1 << 9,
        S_NORM = 28'd1 << 10,
        S_LOG0 = 28'd1 << 11,
        S_LOG1 = 28'd1 << 12,
        S_LOG2 = 28'd1 << 13,
        S_LOG3 = 28'd1 << 14,
        S_LOG4 = 28'd1 << 15,
        S_LOG5 = 28'd1 << 16,
        S_LOG6 = 28'd1 << 17,
        S_EXP0 = 28'd1 << 18,
        S_EXP1 = 28'd1 << 19,
        S_EXP2 = 28'd1 << 20,
        S_EXP3 = 28'd1 << 21,
        S_EXP4 = 28'd1 << 22,
        S_EXP5 = 28'd1 << 23,
        S_EXP6 = 28'd1 << 24,
        S_FIN0 = 28'd1 << 25,
        S_FIN1 = 28'd1 << 26,
        S_DONE = 28'd1 << 27
    } t_state;

    function automatic logic signed [SW-1:0] f_sat(input logic signed [ACCW-1:0] v);
        if (v > SMAX_A) begin
            return SW'(SMAX_A);
        end
        if (v < SMIN_A) begin
            return SW'(SMIN_A);
        end
        return SW'(v);
    endfunction

    // Configuration registers
    logic [16:0]        r_amount;
    logic signed [14:0] r_thr;
    logic signed [16:0] r_slope;
    logic [23:0]        r_att;
    logic [23:0]        r_rel;
    logic signed [31:0] r_b0;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_a2;

    // Filter and envelope state
    logic signed [SW-1:0] r_hin  [4];
    logic signed [SW-1:0] r_hout [4];
    logic [EW-1:0]        r_env;

    // Sequencer and working registers
    t_state                 r_state;
    t_state                 n_state;
    logic                   r_outer;
    logic signed [SW-1:0]   r_x;
    logic signed [SW-1:0]   r_low;
    logic signed [SW-1:0]   r_band_in;
    logic signed [SW-1:0]   r_band;
    logic signed [SW-1:0]   r_res;
    logic signed [14:0]     r_gain;
    logic signed [ACCW-1:0] r_acc;
    logic [EW-1:0]          r_norm;
    logic [CW-1:0]          r_shift;
    logic [IW-1:0]          r_idx;
    logic [29:0]            r_rem;
    t_tab                   r_t1;
    logic [5:0]             r_s;

    // Output register
    logic                 r_ov;
    logic signed [SW-1:0] r_osamp;
    logic signed [14:0]   r_ogr;

    // Datapath wires
    logic signed [OPW-1:0]  w_ma;
    logic signed [OPW-1:0]  w_mb;
    logic signed [PW-1:0]   w_p;
    logic                   w_tsel;
    logic [IW-1:0]          w_taddr;
    t_tab                   w_tdat;
    t_tab                   w_tdiff;
    logic signed [SW-1:0]   w_xin;
    logic signed [SW-1:0]   w_h [4];
    logic [SW-1:0]          w_abs;
    logic [EW-1:0]          w_tgt;
    logic signed [SW+2:0]   w_ediff;
    logic [23:0]            w_coef;
    logic signed [PW-1:0]   w_q;
    logic signed [PW-1:0]   w_ne;
    logic [EW-1:0]          w_nenv;
    logic [EW+28:0]         w_frx;
    logic [29:0]            w_frac30;
    logic [IW-1:0]          w_lidx;
    logic [IW-1:0]          w_eidx;
    logic [18:0]            w_lf;
    logic signed [LGW-1:0]  w_lg;
    logic signed [PW-1:0]   w_db;
    logic signed [PW-1:0]   w_over;
    logic signed [PW-1:0]   w_g;
    logic signed [14:0]     w_gcl;
    logic signed [PW-1:0]   w_ex;
    logic signed [PW-1:0]   w_ip;
    logic [5:0]             w_s;
    logic [18:0]            w_m;
    logic [19:0]            w_v;
    logic [19:0]            w_glin;
    logic signed [ACCW-1:0] w_accr;
    logic signed [SW-1:0]   w_y;
    logic signed [SW-1:0]   w_fy;
    logic                   w_in_acc;
    logic                   w_load;

    bbce_mul #(.OPW(OPW)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    bbce_tab #(.DEPTH(LOG_TABLE_DEPTH)) u_tab (
        .i_clk     (i_clk),
        .i_sel_exp (w_tsel),
        .i_idx     (w_taddr),
        .o_data    (w_tdat)
    );

    assign w_in_acc = i_in.valid && i_in.ready;
    assign w_load   = (r_state == S_DONE) && (!r_ov || o_out.ready);

    // Filter operand select
    always_comb begin
        w_xin = r_outer ? r_band_in : r_x;
        for (int k = 0; k < 4; k++) begin
            w_h[k] = r_outer ? r_hout[k] : r_hin[k];
        end
    end

    // Envelope follower terms
    always_comb begin
        w_abs   = r_low[SW-1] ? SW'(-r_low) : SW'(r_low);
        w_tgt   = {w_abs, 2'b00};
        w_ediff = $signed({1'b0, w_tgt}) - $signed({1'b0, r_env});
        w_coef  = (w_tgt > r_env) ? r_att : r_rel;
        w_q     = (w_p + RND23) >>> 24;
        w_ne    = $signed(PW'(r_env)) + w_q;
        if (w_ne < 0) begin
            w_nenv = '0;
        end else if (w_ne > $signed(PW'(ENV_MAX))) begin
            w_nenv = ENV_MAX;
        end else begin
            w_nenv = w_ne[EW-1:0];
        end
    end

    // Log domain terms
    always_comb begin
        w_frx    = {r_norm[EW-2:0], 30'b0};
        w_frac30 = w_frx[EW+28 -: 30];
        w_lidx   = (w_p[30 +: IW] >= IW'(LOG_TABLE_DEPTH)) ?
                   IW'(LOG_TABLE_DEPTH - 1) : w_p[30 +: IW];
        w_tdiff  = w_tdat - r_t1;
        w_lf     = 19'(r_t1) + 19'(w_p[30 +: 18]);
        w_lg     = LGW'(w_lf) - LGW'({r_shift, 16'b0});
        w_db     = (w_p + RND23) >>> 24;
        w_over   = w_db - PW'(r_thr);
        w_g      = (w_p + RND15) >>> 16;
        if (w_g > 0) begin
            w_gcl = '0;
        end else if (w_g < PW'(GAIN_FLOOR)) begin
            w_gcl = GAIN_FLOOR;
        end else begin
            w_gcl = w_g[14:0];
        end
    end

    // Linear gain terms
    always_comb begin
        w_ex = (w_p + RND7) >>> 8;
        w_ip = w_ex >>> 16;
        if (w_ip >= 0) begin
            w_s = '0;
        end else if (w_ip < -PW'(40)) begin
            w_s = 6'd40;
        end else begin
            w_s = 6'(-w_ip);
        end
        w_eidx = (w_p[16 +: IW] >= IW'(LOG_TABLE_DEPTH)) ?
                 IW'(LOG_TABLE_DEPTH - 1) : w_p[16 +: IW];
        w_m    = 19'(r_t1) + 19'(w_p[16 +: 18]);
        w_v    = {w_m, 1'b0} >> r_s;
        w_glin = (w_v + 20'd1) >> 1;
    end

    // Rounding and saturation of filter sums and the final mix
    always_comb begin
        w_accr = (r_acc + RND27) >>> 28;
        w_y    = f_sat(w_accr);
        w_fy   = f_sat(ACCW'(r_x) + ACCW'((w_p + RND15) >>> 16));
    end

    // Multiplier operand and table address select
    always_comb begin
        w_ma    = '0;
        w_mb    = '0;
        w_tsel  = 1'b0;
        w_taddr = '0;
        unique case (r_state)
            S_F0:   begin w_ma = OPW'(r_b0);    w_mb = OPW'(w_xin);  end
            S_F1:   begin w_ma = OPW'(r_b0);    w_mb = OPW'(w_h[0]); end
            S_F2:   begin w_ma = OPW'(r_b0);    w_mb = OPW'(w_h[1]); end
            S_F3:   begin w_ma = OPW'(r_a1);    w_mb = OPW'(w_h[2]); end
            S_F4:   begin w_ma = OPW'(r_a2);    w_mb = OPW'(w_h[3]); end
            S_ENV0: begin w_ma = OPW'(w_ediff); w_mb = OPW'(w_coef); end
            S_LOG0: begin w_ma = OPW'(w_frac30); w_mb = OPW'(LOG_TABLE_DEPTH); end
            S_LOG1: begin w_taddr = w_lidx; end
            S_LOG2: begin w_taddr = r_idx + IW'(1); end
            S_LOG3: begin w_ma = OPW'(w_tdiff); w_mb = OPW'(r_rem); end
            S_LOG4: begin w_ma = OPW'(w_lg);    w_mb = OPW'(DB_PER_OCT_Q16); end
            S_LOG5: begin w_ma = OPW'(w_over);  w_mb = OPW'(r_slope); end
            S_EXP0: begin w_ma = OPW'(r_gain);  w_mb = OPW'(OCT_PER_DB_Q16); end
            S_EXP1: begin w_ma = OPW'(w_ex[15:0]); w_mb = OPW'(LOG_TABLE_DEPTH); end
            S_EXP2: begin w_tsel = 1'b1; w_taddr = w_eidx; end
            S_EXP3: begin w_tsel = 1'b1; w_taddr = r_idx + IW'(1); end
            S_EXP4: begin w_ma = OPW'(w_tdiff); w_mb = OPW'(r_rem); end
            S_EXP5: begin w_ma = OPW'(r_low);   w_mb = OPW'(w_glin); end
            S_FIN0: begin w_ma = OPW'(r_band);  w_mb = OPW'(r_amount); end
            default: begin end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) begin
                n_state = (r_amount == '0) ? S_DONE : S_F0;
            end
            S_F0:   n_state = S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = S_F4;
            S_F4:   n_state = S_F5;
            S_F5:   n_state = S_F6;
            S_F6:   n_state = r_outer ? S_FIN0 : S_ENV0;
            S_ENV0: n_state = S_ENV1;
            S_ENV1: n_state = (w_nenv == '0) ? S_F0 : S_NORM;
            S_NORM: if (r_norm[EW-1]) begin
                n_state = S_LOG0;
            end
            S_LOG0: n_state = S_LOG1;
            S_LOG1: n_state = S_LOG2;
            S_LOG2: n_state = S_LOG3;
            S_LOG3: n_state = S_LOG4;
            S_LOG4: n_state = S_LOG5;
            S_LOG5: n_state = (w_over > 0) ? S_LOG6 : S_F0;
            S_LOG6: n_state = S_EXP0;
            S_EXP0: n_state = S_EXP1;
            S_EXP1: n_state = S_EXP2;
            S_EXP2: n_state = S_EXP3;
            S_EXP3: n_state = S_EXP4;
            S_EXP4: n_state = S_EXP5;
            S_EXP5: n_state = S_EXP6;
            S_EXP6: n_state = S_F0;
            S_FIN0: n_state = S_FIN1;
            S_FIN1: n_state = S_DONE;
            S_DONE: if (w_load) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration, filter state and envelope
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_amount <= RST_AMOUNT;
            r_thr    <= RST_THRESHOLD;
            r_slope  <= RST_SLOPE;
            r_att    <= RST_ATTACK;
            r_rel    <= RST_RELEASE;
            r_b0     <= RST_B0;
            r_a1     <= RST_A1;
            r_a2     <= RST_A2;
            r_env    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_hin[k]  <= '0;
                r_hout[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Hold the result until the sink takes it
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_AMOUNT:    r_amount <= i_cfg_data[16:0];
                    CFG_THRESHOLD: r_thr    <= i_cfg_data[14:0];
                    CFG_SLOPE:     r_slope  <= i_cfg_data[16:0];
                    CFG_ATTACK:    r_att    <= i_cfg_data[23:0];
                    CFG_RELEASE:   r_rel    <= i_cfg_data[23:0];
                    CFG_B0:        r_b0     <= i_cfg_data;
                    CFG_A1:        r_a1     <= i_cfg_data;
                    CFG_A2:        r_a2     <= i_cfg_data;
                    default:       begin end
                endcase
            end

            // Advance filter history after rounding
            if (r_state == S_F6) begin
                if (r_outer) begin
                    r_hout[1] <= r_hout[0];
                    r_hout[0] <= w_xin;
                    r_hout[3] <= r_hout[2];
                    r_hout[2] <= w_y;
                end else begin
                    r_hin[1] <= r_hin[0];
                    r_hin[0] <= w_xin;
                    r_hin[3] <= r_hin[2];
                    r_hin[2] <= w_y;
                end
            end

            if (r_state == S_ENV1) begin
                r_env <= w_nenv;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (w_in_acc) begin
                r_x     <= i_in.in_sample;
                r_res   <= i_in.in_sample;
                r_gain  <= '0;
                r_outer <= 1'b0;
            end
            S_F1: r_acc <= ACCW'(w_p);
            S_F2: r_acc <= r_acc + (ACCW'(w_p) <<< 1);
            S_F3: r_acc <= r_acc + ACCW'(w_p);
            S_F4: r_acc <= r_acc - ACCW'(w_p);
            S_F5: r_acc <= r_acc - ACCW'(w_p);
            S_F6: begin
                if (r_outer) begin
                    r_band <= w_y;
                end else begin
                    r_low <= w_y;
                end
            end
            S_ENV1: begin
                r_norm    <= w_nenv;
                r_shift   <= '0;
                r_band_in <= r_low;
                r_outer   <= (w_nenv == '0);
            end
            S_NORM: if (!r_norm[EW-1]) begin
                r_norm  <= r_norm << 1;
                r_shift <= r_shift + CW'(1);
            end
            S_LOG1: begin
                r_idx <= w_lidx;
                r_rem <= w_p[29:0];
            end
            S_LOG2: r_t1 <= w_tdat;
            S_LOG5: if (!(w_over > 0)) begin
                r_outer <= 1'b1;
            end
            S_LOG6: r_gain <= w_gcl;
            S_EXP1: r_s <= w_s;
            S_EXP2: begin
                r_idx <= w_eidx;
                r_rem <= 30'(w_p[15:0]);
            end
            S_EXP3: r_t1 <= w_tdat;
            S_EXP6: begin
                r_band_in <= SW'((w_p + RND15) >>> 16);
                r_outer   <= 1'b1;
            end
            S_FIN1: r_res <= w_fy;
            default: begin end
        endcase

        if (w_load) begin
            r_osamp <= r_res;
            r_ogr   <= r_gain;
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_ov;
    assign o_out.out_sample     = r_osamp;
    assign o_out.gain_reduction = r_ogr;

endmodule

FILE: sv/bbce_mul.sv
// Shared signed multiplier with a registered product.
module bbce_mul #(
    parameter int OPW = 33
) (
    input  logic                    i_clk,
    input  logic signed [OPW-1:0]   i_a,
    input  logic signed [OPW-1:0]   i_b,
    output logic signed [2*OPW-1:0] o_p
);

    logic signed [2*OPW-1:0] r_p;

    // Register the product for the next sequencer step
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: sv/bbce_tab.sv
// Log2 and exp2 interpolation tables with a registered read port.
module bbce_tab import bbce_pkg::*; #(
    parameter int DEPTH = 64,
    localparam int IW = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_sel_exp,
    input  logic [IW-1:0] i_idx,
    output t_tab          o_data
);

    // log2 of a Q2.30 value in [1,2) as Q0.20, by repeated squaring
    function automatic logic [63:0] f_log2_frac20(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] r;
        x = x_in;
        r = '0;
        for (int k = 0; k < 20; k++) begin
            x = (x * x) >> 30;
            r = r << 1;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                r = r | 64'd1;
            end
        end
        return r;
    endfunction

    function automatic t_tab f_log_ent(input int i);
        logic [63:0] v;
        if (i == DEPTH) begin
            return t_tab'(65536);
        end
        v = ((64'(DEPTH) + 64'(i)) << 30) / DEPTH;
        return t_tab'((f_log2_frac20(v) + 64'd8) >> 4);
    endfunction

    function automatic t_tab f_exp_ent(input int i);
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        if (i == DEPTH) begin
            return t_tab'(131072);
        end
        target = ((64'(i) << 20) + 64'(DEPTH / 2)) / DEPTH;
        lo = 64'd1 << 30;
        hi = 64'd1 << 31;
        for (int k = 0; k < 32; k++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (f_log2_frac20(mid) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 64'd1;
                end
            end
        end
        return t_tab'((lo + (64'd1 << 13)) >> 14);
    endfunction

    t_tab w_log [DEPTH+1];
    t_tab w_exp [DEPTH+1];
    t_tab r_data;

    // Constant table contents
    for (genvar g = 0; g <= DEPTH; g++) begin : g_ent
        assign w_log[g] = f_log_ent(g);
        assign w_exp[g] = f_exp_ent(g);
    end

    // Registered lookup
    always_ff @(posedge i_clk) begin
        if (i_idx <= IW'(DEPTH)) begin
            r_data <= i_sel_exp ? w_exp[i_idx] : w_log[i_idx];
        end else begin
            r_data <= '0;
        end
    end

    assign o_data = r_data;

endmodule

FILE: sv/bbce_chk.sv
// Port checker for the bass band compressor enhancer, bound to the top level.
module bbce_chk #(
    parameter int SW = 24
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic signed [SW-1:0] i_out_sample,
    input logic signed [14:0]   i_out_gain
);

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // The block is busy right after taking a word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accept");

    // Reported gain stays within its range
    a_gain_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_gain <= 15'sd0 && i_out_gain >= -15'sd12800))
        else $error("gain out of range");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_sample) && $stable(i_out_gain)))
        else $error("stalled result changed");

endmodule

bind bass_band_compress_enhancer bbce_chk #(.SW(SAMPLE_WIDTH)) u_bbce_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.out_sample),
    .i_out_gain   (o_out.gain_reduction)
);
